// ===== rtl/core/baro_comp_pkg.sv =====
// ----------------------------------------------------------------------------
// Barometric compensation package
// Shared word types, register indexes, status codes, the pipeline depth and
// the PROM CRC-4 bit weights used by the compensation pipeline and its checker.
// ----------------------------------------------------------------------------
package baro_comp_pkg;

  localparam int unsigned NUM_PROM_WORDS = 8;
  localparam int unsigned NUM_STAGES     = 9;
  localparam logic [15:0] CRC_POLY       = 16'h3000;

  typedef enum logic [2:0] {
    REG_PROM_WORD0       = 3'd0,
    REG_SENS_COEF        = 3'd1,
    REG_OFFSET_COEF      = 3'd2,
    REG_SENS_TEMP_COEF   = 3'd3,
    REG_OFFSET_TEMP_COEF = 3'd4,
    REG_REF_TEMP_COEF    = 3'd5,
    REG_TEMP_SLOPE_COEF  = 3'd6,
    REG_PROM_WORD7       = 3'd7
  } reg_index_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_CRC_ERR   = 2'd1,
    STATUS_ZERO_READ = 2'd2
  } status_t;

  typedef struct packed {
    logic [23:0] raw_pressure;
    logic [23:0] raw_temperature;
  } reading_t;

  typedef struct packed {
    logic signed [18:0] temperature;
    logic signed [31:0] pressure;
    status_t            status;
  } result_t;

  // CRC-4 of a message that has a single bit set: bit bit_idx of PROM word
  // word_idx, bytes fed high byte first. The CRC is linear, so the CRC of
  // the whole PROM is the XOR of these weights over its set bits. Only
  // called with constant arguments.
  function automatic logic [3:0] crc_bit_weight(input int unsigned word_idx,
                                                input int unsigned bit_idx);
    logic [15:0] rem;
    logic [7:0]  byte_val;
    int unsigned tgt;
    rem = '0;
    tgt = 2 * word_idx + ((bit_idx >= 8) ? 0 : 1);
    for (int unsigned n = 0; n < 2 * NUM_PROM_WORDS; n++) begin
      byte_val = (n == tgt) ? 8'(1 << (bit_idx & 7)) : 8'h00;
      rem = rem ^ {8'h00, byte_val};
      for (int unsigned b = 0; b < 8; b++) begin
        if (rem[15]) begin
          rem = {rem[14:0], 1'b0} ^ CRC_POLY;
        end else begin
          rem = {rem[14:0], 1'b0};
        end
      end
    end
    return rem[15:12];
  endfunction

endpackage

// ===== rtl/core/baro_sensor_compensation.sv =====
// ----------------------------------------------------------------------------
// Barometric sensor compensation
// Throughput: one reading word per cycle while the result is not stalled,
// set by the 9-stage pipeline; a stalled result holds only the unbroken run
// of full stages behind it. Reset: synchronous; clears the PROM registers,
// the CRC check and all valid bits. A PROM write reaches the CRC check via
// the registered per-word partial CRCs and then the registered error flag.
// ----------------------------------------------------------------------------
module baro_sensor_compensation (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  reading_valid,
  output logic                  reading_stall,
  input  baro_comp_pkg::reading_t reading,
  output logic                  result_valid,
  input  logic                  result_stall,
  output baro_comp_pkg::result_t  result,
  input  logic                  cfg_write_en,
  input  logic [2:0]            cfg_index,
  input  logic [15:0]           cfg_data
);

  // --------------------------------------------------------------------------
  // PROM registers and CRC check
  // --------------------------------------------------------------------------
  logic [15:0] prom [baro_comp_pkg::NUM_PROM_WORDS];
  logic [15:0] prom_crc_view [baro_comp_pkg::NUM_PROM_WORDS];
  logic [3:0]  crc_contrib [baro_comp_pkg::NUM_PROM_WORDS][16];
  logic [3:0]  crc_part_next [baro_comp_pkg::NUM_PROM_WORDS];
  logic [3:0]  crc_part [baro_comp_pkg::NUM_PROM_WORDS];
  logic [3:0]  crc_sum;
  logic        crc_bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < baro_comp_pkg::NUM_PROM_WORDS; i++) begin
        prom[i] <= '0;
      end
    end else if (cfg_write_en) begin
      prom[cfg_index] <= cfg_data;
    end
  end

  // Zero the low byte of word 7, which holds the CRC, before it enters the check.
  always_comb begin
    for (int i = 0; i < baro_comp_pkg::NUM_PROM_WORDS; i++) begin
      prom_crc_view[i] = prom[i];
    end
    prom_crc_view[baro_comp_pkg::REG_PROM_WORD7] =
      {prom[baro_comp_pkg::REG_PROM_WORD7][15:8], 8'h00};
  end

  for (genvar k = 0; k < baro_comp_pkg::NUM_PROM_WORDS; k++) begin : g_crc_word
    for (genvar b = 0; b < 16; b++) begin : g_crc_bit
      localparam logic [3:0] WEIGHT = baro_comp_pkg::crc_bit_weight(k, b);
      assign crc_contrib[k][b] = prom_crc_view[k][b] ? WEIGHT : 4'h0;
    end
  end

  always_comb begin
    for (int k = 0; k < baro_comp_pkg::NUM_PROM_WORDS; k++) begin
      crc_part_next[k] = 4'h0;
      for (int b = 0; b < 16; b++) begin
        crc_part_next[k] = crc_part_next[k] ^ crc_contrib[k][b];
      end
    end
  end

  always_comb begin
    crc_sum = 4'h0;
    for (int k = 0; k < baro_comp_pkg::NUM_PROM_WORDS; k++) begin
      crc_sum = crc_sum ^ crc_part[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < baro_comp_pkg::NUM_PROM_WORDS; k++) begin
        crc_part[k] <= 4'h0;
      end
      crc_bad <= 1'b0;
    end else begin
      crc_part <= crc_part_next;
      crc_bad  <= (crc_sum != prom[baro_comp_pkg::REG_PROM_WORD7][3:0]);
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: a stage loads when it is empty or its successor moves
  // --------------------------------------------------------------------------
  logic [baro_comp_pkg::NUM_STAGES:1] vld;
  logic [baro_comp_pkg::NUM_STAGES:1] rdy;

  assign rdy[baro_comp_pkg::NUM_STAGES] = !vld[baro_comp_pkg::NUM_STAGES] || !result_stall;
  for (genvar i = 1; i < baro_comp_pkg::NUM_STAGES; i++) begin : g_rdy
    assign rdy[i] = !vld[i] || rdy[i+1];
  end

  assign reading_stall = !rdy[1];
  assign result_valid  = vld[baro_comp_pkg::NUM_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) begin
        vld[1] <= reading_valid;
      end
      for (int i = 2; i <= baro_comp_pkg::NUM_STAGES; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: dT = D2 - C5 * 256, zero-reading flag
  // --------------------------------------------------------------------------
  logic [23:0]        s1_d1;
  logic signed [25:0] s1_dt;
  logic               s1_zero;
  logic signed [25:0] dt_next;

  assign dt_next = $signed({2'b00, reading.raw_temperature})
                 - $signed({2'b00, prom[baro_comp_pkg::REG_REF_TEMP_COEF], 8'h00});

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_d1   <= reading.raw_pressure;
      s1_dt   <= dt_next;
      s1_zero <= (reading.raw_pressure == 24'd0) || (reading.raw_temperature == 24'd0);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: products of dT with C6, C4, C3 and itself
  // --------------------------------------------------------------------------
  logic signed [42:0] s2_tprod, s2_oprod, s2_sprod;
  logic signed [20:0] s2_t2;
  logic [23:0]        s2_d1;
  logic               s2_zero;
  logic signed [42:0] tprod_next, oprod_next, sprod_next;
  logic signed [51:0] dd_next;

  assign tprod_next = s1_dt * $signed({1'b0, prom[baro_comp_pkg::REG_TEMP_SLOPE_COEF]});
  assign oprod_next = s1_dt * $signed({1'b0, prom[baro_comp_pkg::REG_OFFSET_TEMP_COEF]});
  assign sprod_next = s1_dt * $signed({1'b0, prom[baro_comp_pkg::REG_SENS_TEMP_COEF]});
  assign dd_next    = s1_dt * s1_dt;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_tprod <= tprod_next;
      s2_oprod <= oprod_next;
      s2_sprod <= sprod_next;
      s2_t2    <= $signed(dd_next[51:31]);
      s2_d1    <= s1_d1;
      s2_zero  <= s1_zero;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: TEMP - 2000, first-order OFF and SENS
  // --------------------------------------------------------------------------
  logic signed [19:0] s3_tdiff;
  logic signed [41:0] s3_off, s3_sens;
  logic signed [20:0] s3_t2;
  logic [23:0]        s3_d1;
  logic               s3_zero;
  logic signed [41:0] off_next, sens_next;

  assign off_next  = $signed({10'b0, prom[baro_comp_pkg::REG_OFFSET_COEF], 16'h0000})
                   + 42'($signed(s2_oprod[42:7]));
  assign sens_next = $signed({11'b0, prom[baro_comp_pkg::REG_SENS_COEF], 15'h0000})
                   + 42'($signed(s2_sprod[42:8]));

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_tdiff <= $signed(s2_tprod[42:23]);
      s3_off   <= off_next;
      s3_sens  <= sens_next;
      s3_t2    <= s2_t2;
      s3_d1    <= s2_d1;
      s3_zero  <= s2_zero;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: squares for the low-temperature corrections, final TEMP
  // --------------------------------------------------------------------------
  logic signed [39:0] s4_a;
  logic signed [41:0] s4_b;
  logic               s4_low, s4_vlow;
  logic signed [20:0] s4_temp;
  logic signed [41:0] s4_off, s4_sens;
  logic [23:0]        s4_d1;
  logic               s4_zero;
  logic signed [20:0] tplus;
  logic               low_next;
  logic signed [20:0] temp_next;

  assign tplus     = 21'(s3_tdiff) + 21'sd3500;
  assign low_next  = s3_tdiff[19];
  assign temp_next = 21'(s3_tdiff) + 21'sd2000 - (low_next ? s3_t2 : 21'sd0);

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_a    <= s3_tdiff * s3_tdiff;
      s4_b    <= tplus * tplus;
      s4_low  <= low_next;
      s4_vlow <= (s3_tdiff < -20'sd3500);
      s4_temp <= temp_next;
      s4_off  <= s3_off;
      s4_sens <= s3_sens;
      s4_d1   <= s3_d1;
      s4_zero <= s3_zero;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: OFF2 and SENS2
  // --------------------------------------------------------------------------
  logic signed [41:0] s5_off2, s5_sens2;
  logic signed [20:0] s5_temp;
  logic signed [41:0] s5_off, s5_sens;
  logic [23:0]        s5_d1;
  logic               s5_zero;
  logic signed [41:0] a_ext, a_x5, b_x7, b_x11;
  logic signed [41:0] off2_next, sens2_next;

  assign a_ext = 42'(s4_a);
  assign a_x5  = (a_ext <<< 2) + a_ext;
  assign b_x7  = (s4_b <<< 3) - s4_b;
  assign b_x11 = (s4_b <<< 3) + (s4_b <<< 1) + s4_b;

  always_comb begin
    off2_next  = '0;
    sens2_next = '0;
    if (s4_low) begin
      off2_next  = (a_x5 >>> 1) + (s4_vlow ? b_x7 : 42'sd0);
      sens2_next = (a_x5 >>> 2) + (s4_vlow ? (b_x11 >>> 1) : 42'sd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s5_off2  <= off2_next;
      s5_sens2 <= sens2_next;
      s5_temp  <= s4_temp;
      s5_off   <= s4_off;
      s5_sens  <= s4_sens;
      s5_d1    <= s4_d1;
      s5_zero  <= s4_zero;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: corrected OFF and SENS
  // --------------------------------------------------------------------------
  logic signed [41:0] s6_off, s6_sens;
  logic signed [20:0] s6_temp;
  logic [23:0]        s6_d1;
  logic               s6_zero;

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      s6_off  <= s5_off - s5_off2;
      s6_sens <= s5_sens - s5_sens2;
      s6_temp <= s5_temp;
      s6_d1   <= s5_d1;
      s6_zero <= s5_zero;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: D1 * SENS as two partial products split at bit 21
  // --------------------------------------------------------------------------
  logic [44:0]        s7_lo;
  logic signed [45:0] s7_hi;
  logic signed [41:0] s7_off;
  logic signed [20:0] s7_temp;
  logic               s7_zero;

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      s7_lo   <= s6_d1 * s6_sens[20:0];
      s7_hi   <= $signed({1'b0, s6_d1}) * $signed(s6_sens[41:21]);
      s7_off  <= s6_off;
      s7_temp <= s6_temp;
      s7_zero <= s6_zero;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 8: D1 * SENS / 2^21 - OFF
  // --------------------------------------------------------------------------
  logic signed [47:0] s8_q;
  logic signed [20:0] s8_temp;
  logic               s8_zero;

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      s8_q    <= 48'(s7_hi) + $signed({24'b0, s7_lo[44:21]}) - 48'(s7_off);
      s8_temp <= s7_temp;
      s8_zero <= s7_zero;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 9: output register, status and error masking
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rdy[9]) begin
      if (crc_bad) begin
        result.status      <= baro_comp_pkg::STATUS_CRC_ERR;
        result.temperature <= '0;
        result.pressure    <= '0;
      end else if (s8_zero) begin
        result.status      <= baro_comp_pkg::STATUS_ZERO_READ;
        result.temperature <= '0;
        result.pressure    <= '0;
      end else begin
        result.status      <= baro_comp_pkg::STATUS_OK;
        result.temperature <= s8_temp[18:0];
        result.pressure    <= s8_q[46:15];
      end
    end
  end

endmodule

// ===== rtl/core/baro_comp_checker.sv =====
// ----------------------------------------------------------------------------
// Barometric compensation checker
// Port-level assertions on the compensation pipeline, bound to its top.
// ----------------------------------------------------------------------------
module baro_comp_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   reading_stall,
  input logic                   result_valid,
  input logic                   result_stall,
  input baro_comp_pkg::result_t result
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result word valid after reset");

  // Hold a stalled result word.
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result word changed");

  // An empty output stage means every stage can advance.
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !reading_stall)
    else $error("input stalled with empty output stage");

  // Error words carry zero temperature and pressure.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status != baro_comp_pkg::STATUS_OK)
      |-> (result.temperature == '0) && (result.pressure == '0))
    else $error("error word carries nonzero data");

endmodule

bind baro_sensor_compensation baro_comp_checker u_baro_comp_checker (.*);
